/* rtl/mcpr_pkg.sv */
`default_nettype none
package mcpr_pkg;

  localparam int CHANNELS = 8;
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Q1.16 unity for progress
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] PH_START   = 2'd0;
  localparam logic [1:0] PH_RESTART = 2'd1;
  localparam logic [1:0] PH_RAMP    = 2'd2;
  localparam logic [1:0] PH_ARRIVED = 2'd3;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [2:0]         channel;
    logic [15:0]        ramp_ms;
    logic signed [15:0] target_position;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] position;
    logic               arrived;
  } out_item_t;

  typedef struct packed {
    logic        start;
    logic [15:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

endpackage
`default_nettype wire

/* rtl/mcpr_div.sv */
`default_nettype none
// Restoring divider: quotient = (dividend << 16) / divisor, dividend < divisor,
// one quotient bit per cycle.
module mcpr_div (
  input  wire                 clk,
  input  wire                 rst,
  input  mcpr_pkg::div_req_t  req,
  output logic                done,
  output logic [15:0]         quotient
);

  logic        busy;
  logic [3:0]  cnt;
  logic [15:0] rem;
  logic [15:0] divisor;
  logic [16:0] rem_shift;
  logic        fits;

  assign rem_shift = {rem, 1'b0};
  assign fits      = rem_shift >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        rem      <= req.dividend;
        divisor  <= req.divisor;
        quotient <= '0;
      end else if (busy) begin
        if (fits) begin
          rem <= 16'(rem_shift - {1'b0, divisor});
        end else begin
          rem <= rem_shift[15:0];
        end
        quotient <= {quotient[14:0], fits};
        cnt      <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/multi_channel_position_ramp_unit.sv */
`default_nettype none
// Channel   Direction  Payload               Handshake
// item      in         mcpr_pkg::in_item_t   item_valid / item_stall
// result    out        mcpr_pkg::out_item_t  result_valid / result_stall
//
// Tick and clear transactions take effect in the accept cycle; the input stays open.
// A query holds the input until its result is loaded; the long path is a ramp step,
// through the serial divider, one multiply and one add.
// The result register frees the input while a finished result waits to be taken;
// a query finishing while that register is still stalled holds until it drains.
// Synchronous reset returns all channels to position 0, phase start.
module multi_channel_position_ramp_unit (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  item_valid,
  output logic                 item_stall,
  input  mcpr_pkg::in_item_t   item,
  output logic                 result_valid,
  input  wire                  result_stall,
  output mcpr_pkg::out_item_t  result
);

  localparam int CW = mcpr_pkg::CH_IDX_W;
  localparam int NCH = mcpr_pkg::CHANNELS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_STEP = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_ADD  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state;

  logic [1:0]         phase        [NCH];
  logic [16:0]        progress     [NCH];
  logic signed [15:0] start_pos    [NCH];
  logic signed [15:0] prior_target [NCH];
  logic signed [15:0] current_pos  [NCH];
  logic [31:0]        last_stamp   [NCH];
  logic [31:0]        tick_count;

  mcpr_pkg::in_item_t cur;
  logic [31:0]        elapsed;
  logic signed [34:0] prod;
  logic signed [15:0] res_pos;
  logic               res_arr;

  logic [CW-1:0]      cidx;
  logic               out_of_range;
  logic               restart;
  logic signed [15:0] tgt;
  logic [1:0]         ph;
  logic signed [16:0] diff;
  logic signed [34:0] prod_round;
  logic signed [34:0] prod_shift;
  logic signed [15:0] lerp_pos;
  logic [17:0]        sum;
  logic               accept;

  mcpr_pkg::div_req_t div_req;
  logic               div_done;
  logic [15:0]        div_q;

  assign accept       = item_valid && !item_stall;
  assign item_stall   = state != S_IDLE;
  assign cidx         = CW'(cur.channel);
  assign out_of_range = 32'(cur.channel) >= 32'(NCH);
  assign tgt          = cur.target_position;
  assign ph           = phase[cidx];
  // phase start behaves as restart, start_pos is reloaded anyway
  assign restart      = ph == mcpr_pkg::PH_START || ph == mcpr_pkg::PH_RESTART ||
                        tgt != prior_target[cidx];
  assign diff         = 17'(tgt) - 17'(start_pos[cidx]);
  assign prod_round   = prod + 35'sd32768;
  assign prod_shift   = prod_round >>> 16;
  assign lerp_pos     = start_pos[cidx] + prod_shift[15:0];
  assign sum          = {1'b0, progress[cidx]} + {2'b0, div_q};

  assign div_req.start    = state == S_STEP && elapsed != 32'd0 &&
                            elapsed < {16'd0, cur.ramp_ms};
  assign div_req.dividend = elapsed[15:0];
  assign div_req.divisor  = cur.ramp_ms;

  mcpr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      tick_count   <= '0;
      for (int i = 0; i < NCH; i++) begin
        phase[i]        <= mcpr_pkg::PH_START;
        progress[i]     <= '0;
        start_pos[i]    <= '0;
        prior_target[i] <= '0;
        current_pos[i]  <= '0;
        last_stamp[i]   <= '0;
      end
    end else begin
      if (result_valid && !result_stall && state != S_DONE) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            cur <= item;
            case (item.cmd)
              mcpr_pkg::CMD_TICK: begin
                tick_count <= tick_count + 32'd1;
              end
              mcpr_pkg::CMD_CLEAR: begin
                tick_count <= '0;
                for (int i = 0; i < NCH; i++) begin
                  phase[i]       <= mcpr_pkg::PH_RESTART;
                  progress[i]    <= '0;
                  start_pos[i]   <= '0;
                  current_pos[i] <= '0;
                end
              end
              mcpr_pkg::CMD_QUERY: begin
                state <= S_LOOK;
              end
              default: begin
              end
            endcase
          end
        end
        S_LOOK: begin
          if (out_of_range) begin
            res_pos <= tgt;
            res_arr <= 1'b0;
            state   <= S_DONE;
          end else if (cur.ramp_ms == 16'd0) begin
            progress[cidx]    <= mcpr_pkg::ONE_Q16;
            phase[cidx]       <= mcpr_pkg::PH_RAMP;
            current_pos[cidx] <= tgt;
            res_pos           <= tgt;
            res_arr           <= 1'b1;
            state             <= S_DONE;
          end else if (restart) begin
            progress[cidx]     <= '0;
            prior_target[cidx] <= tgt;
            last_stamp[cidx]   <= tick_count;
            start_pos[cidx]    <= current_pos[cidx];
            phase[cidx]        <= mcpr_pkg::PH_RAMP;
            res_pos            <= current_pos[cidx];
            res_arr            <= 1'b0;
            state              <= S_DONE;
          end else if (ph == mcpr_pkg::PH_ARRIVED) begin
            current_pos[cidx] <= tgt;
            start_pos[cidx]   <= tgt;
            res_pos           <= tgt;
            res_arr           <= progress[cidx] == mcpr_pkg::ONE_Q16;
            state             <= S_DONE;
          end else begin
            elapsed <= tick_count - last_stamp[cidx];
            state   <= S_STEP;
          end
        end
        S_STEP: begin
          if (elapsed == 32'd0) begin
            res_pos <= current_pos[cidx];
            res_arr <= progress[cidx] == mcpr_pkg::ONE_Q16;
            state   <= S_DONE;
          end else begin
            last_stamp[cidx] <= tick_count;
            if (elapsed >= {16'd0, cur.ramp_ms}) begin
              // increment is at least one full ramp
              progress[cidx] <= mcpr_pkg::ONE_Q16;
              phase[cidx]    <= mcpr_pkg::PH_ARRIVED;
              state          <= S_MUL;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (sum >= {1'b0, mcpr_pkg::ONE_Q16}) begin
              progress[cidx] <= mcpr_pkg::ONE_Q16;
              phase[cidx]    <= mcpr_pkg::PH_ARRIVED;
            end else begin
              progress[cidx] <= sum[16:0];
            end
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= diff * $signed({1'b0, progress[cidx]});
          state <= S_ADD;
        end
        S_ADD: begin
          current_pos[cidx] <= lerp_pos;
          res_pos           <= lerp_pos;
          res_arr           <= progress[cidx] == mcpr_pkg::ONE_Q16;
          state             <= S_DONE;
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            result_valid     <= 1'b1;
            result.position  <= res_pos;
            result.arrived   <= res_arr;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/mcpr_checker.sv */
`default_nettype none
module mcpr_checker (
  input wire                  clk,
  input wire                  rst,
  input wire                  item_valid,
  input wire                  item_stall,
  input mcpr_pkg::in_item_t   item,
  input wire                  result_valid,
  input wire                  result_stall,
  input mcpr_pkg::out_item_t  result
);

  // a waiting result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // a query occupies the block for at least the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && item.cmd == mcpr_pkg::CMD_QUERY |=> item_stall)
    else $error("query did not hold the input");

  // tick, clear and unused codes leave the input open
  a_other_open: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && item.cmd != mcpr_pkg::CMD_QUERY |=> !item_stall)
    else $error("non-query transaction blocked the input");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !result_valid && !item_stall)
    else $error("not idle after reset");

endmodule

bind multi_channel_position_ramp_unit mcpr_checker u_mcpr_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
`default_nettype wire
